@@ src/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DAR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dar same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define DAR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dar next-cycle check failed");

`endif

@@ src/dar_pkg.sv @@
// Shared types, codes and constants of the aspect ratio reducer.
package dar_pkg;

   localparam int WORD_W           = 16;
   localparam int CAND_W           = 6;
   localparam int PROD_W           = WORD_W + CAND_W;
   localparam int TOL_W            = 7;
   localparam int SCALED_W         = PROD_W + TOL_W;
   localparam int DIV_CNT_W        = $clog2(WORD_W);
   localparam int SEARCH_LIMIT_DEF = 21;
   localparam logic [TOL_W-1:0] TOL_SCALE = TOL_W'(100);

   localparam logic [1:0] DIV_SEL_GCD = 2'd0;
   localparam logic [1:0] DIV_SEL_W   = 2'd1;
   localparam logic [1:0] DIV_SEL_H   = 2'd2;

   localparam logic [1:0] OUT_SEL_RATIO   = 2'd0;
   localparam logic [1:0] OUT_SEL_ZERO    = 2'd1;
   localparam logic [1:0] OUT_SEL_INVALID = 2'd2;

   typedef struct packed {
      logic       accept;
      logic       div_start;
      logic [1:0] div_sel;
      logic       gcd_step;
      logic       wr_w;
      logic       wr_h;
      logic       srch_init;
      logic       srch_step;
      logic       load_pair;
      logic       load_out;
      logic [1:0] out_sel;
   } cmd_type;

   typedef struct packed {
      logic in_zero;
      logic b_zero;
      logic div_done;
      logic rw_gt_limit;
      logic hit;
      logic miss_end;
      logic out_free;
   } sts_type;

endpackage

@@ src/dar_div.sv @@
// Restoring divider, one quotient bit per cycle.
module dar_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [dar_pkg::WORD_W-1:0] dividend,
   input  logic [dar_pkg::WORD_W-1:0] divisor,
   output logic [dar_pkg::WORD_W-1:0] quotient,
   output logic [dar_pkg::WORD_W-1:0] remainder,
   output logic                       done
);

   logic [dar_pkg::WORD_W-1:0]    rem_ff, rem_in;
   logic [dar_pkg::WORD_W-1:0]    quo_ff, quo_in;
   logic [dar_pkg::WORD_W-1:0]    dvs_ff, dvs_in;
   logic [dar_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [dar_pkg::WORD_W:0]      shifted;
   logic [dar_pkg::WORD_W:0]      trial;
   logic                          fits;
   logic                          last_step;

   assign shifted   = {rem_ff, quo_ff[dar_pkg::WORD_W-1]};
   assign trial     = shifted - {1'b0, dvs_ff};
   assign fits      = shifted >= {1'b0, dvs_ff};
   assign last_step = cnt_ff == {dar_pkg::DIV_CNT_W{1'b1}};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[dar_pkg::WORD_W-1:0] : shifted[dar_pkg::WORD_W-1:0];
         quo_in = {quo_ff[dar_pkg::WORD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

@@ src/dar_dpath.sv @@
// Datapath: Euclid operands, divider, candidate search pipe, result register.
module dar_dpath #(
   parameter int SEARCH_LIMIT = dar_pkg::SEARCH_LIMIT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dar_pkg::cmd_type           cmd,
   output dar_pkg::sts_type           sts,
   input  logic [dar_pkg::WORD_W-1:0] req_frame_width,
   input  logic [dar_pkg::WORD_W-1:0] req_frame_height,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [dar_pkg::WORD_W-1:0] rsp_ratio_num,
   output logic [dar_pkg::WORD_W-1:0] rsp_ratio_den,
   output logic                       rsp_invalid
);

   localparam logic [dar_pkg::CAND_W-1:0] LIMIT_C = dar_pkg::CAND_W'(SEARCH_LIMIT);
   localparam logic [dar_pkg::CAND_W-1:0] ONE_C   = dar_pkg::CAND_W'(1);

   logic [dar_pkg::WORD_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [dar_pkg::WORD_W-1:0]   rw_ff, rw_in, rh_ff, rh_in;
   logic [dar_pkg::CAND_W-1:0]   aw_ff, aw_in, ah_ff, ah_in;
   logic [dar_pkg::CAND_W-1:0]   p_aw_ff, p_ah_ff;
   logic [dar_pkg::PROD_W-1:0]   p_lhs_ff, p_rhs_ff;
   logic                         p_last_ff, p_vld_ff;
   logic [dar_pkg::WORD_W-1:0]   num_ff, num_in, den_ff, den_in;
   logic                         inv_ff, inv_in, vld_ff, vld_in;
   logic [dar_pkg::WORD_W-1:0]   div_dividend, div_divisor, div_quo, div_rem;
   logic                         div_done;
   logic [dar_pkg::PROD_W-1:0]   diff;
   logic [dar_pkg::SCALED_W-1:0] scaled;
   logic                         hit;

   dar_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_comb begin
      case (cmd.div_sel)
         dar_pkg::DIV_SEL_W: begin
            div_dividend = rw_ff;
            div_divisor  = a_ff;
         end
         dar_pkg::DIV_SEL_H: begin
            div_dividend = rh_ff;
            div_divisor  = a_ff;
         end
         default: begin
            div_dividend = a_ff;
            div_divisor  = b_ff;
         end
      endcase
   end

   always_comb begin
      a_in  = a_ff;
      b_in  = b_ff;
      rw_in = rw_ff;
      rh_in = rh_ff;
      if (cmd.accept) begin
         a_in  = req_frame_width;
         b_in  = req_frame_height;
         rw_in = req_frame_width;
         rh_in = req_frame_height;
      end else if (cmd.load_pair) begin
         a_in  = dar_pkg::WORD_W'(p_aw_ff);
         b_in  = dar_pkg::WORD_W'(p_ah_ff);
         rw_in = dar_pkg::WORD_W'(p_aw_ff);
         rh_in = dar_pkg::WORD_W'(p_ah_ff);
      end else begin
         if (cmd.gcd_step) begin
            a_in = b_ff;
            b_in = div_rem;
         end
         if (cmd.wr_w) begin
            rw_in = div_quo;
         end
         if (cmd.wr_h) begin
            rh_in = div_quo;
         end
      end
   end

   // candidate order: numerator outer, denominator inner, both counting down
   always_comb begin
      aw_in = aw_ff;
      ah_in = ah_ff;
      if (cmd.srch_init) begin
         aw_in = LIMIT_C;
         ah_in = LIMIT_C;
      end else if (cmd.srch_step) begin
         if (ah_ff == ONE_C) begin
            ah_in = LIMIT_C;
            aw_in = aw_ff - ONE_C;
         end else begin
            ah_in = ah_ff - ONE_C;
         end
      end
   end

   assign diff   = (p_lhs_ff > p_rhs_ff) ? p_lhs_ff - p_rhs_ff : p_rhs_ff - p_lhs_ff;
   assign scaled = dar_pkg::SCALED_W'(diff) * dar_pkg::SCALED_W'(dar_pkg::TOL_SCALE);
   assign hit    = p_vld_ff && (scaled < dar_pkg::SCALED_W'(p_lhs_ff));

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      inv_in = inv_ff;
      vld_in = vld_ff && rsp_stall;
      if (cmd.load_out) begin
         vld_in = 1'b1;
         case (cmd.out_sel)
            dar_pkg::OUT_SEL_RATIO: begin
               num_in = rw_ff;
               den_in = rh_ff;
               inv_in = 1'b0;
            end
            dar_pkg::OUT_SEL_INVALID: begin
               num_in = '0;
               den_in = '0;
               inv_in = 1'b1;
            end
            default: begin
               num_in = '0;
               den_in = '0;
               inv_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      rw_ff     <= rw_in;
      rh_ff     <= rh_in;
      aw_ff     <= aw_in;
      ah_ff     <= ah_in;
      p_aw_ff   <= aw_ff;
      p_ah_ff   <= ah_ff;
      p_lhs_ff  <= dar_pkg::PROD_W'(rw_ff) * dar_pkg::PROD_W'(ah_ff);
      p_rhs_ff  <= dar_pkg::PROD_W'(aw_ff) * dar_pkg::PROD_W'(rh_ff);
      p_last_ff <= (aw_ff == ONE_C) && (ah_ff == ONE_C);
      num_ff    <= num_in;
      den_ff    <= den_in;
      inv_ff    <= inv_in;
      if (reset) begin
         p_vld_ff <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         p_vld_ff <= cmd.srch_step;
         vld_ff   <= vld_in;
      end
   end

   assign sts.in_zero     = (req_frame_width == '0) || (req_frame_height == '0);
   assign sts.b_zero      = b_ff == '0;
   assign sts.div_done    = div_done;
   assign sts.rw_gt_limit = rw_ff > dar_pkg::WORD_W'(SEARCH_LIMIT);
   assign sts.hit         = hit;
   assign sts.miss_end    = p_vld_ff && p_last_ff && !hit;
   assign sts.out_free    = !vld_ff || !rsp_stall;

   assign rsp_valid     = vld_ff;
   assign rsp_ratio_num = num_ff;
   assign rsp_ratio_den = den_ff;
   assign rsp_invalid   = inv_ff;

endmodule

@@ src/dar_ctrl.sv @@
// Controller: sequences Euclid, the reducing divides and the candidate search.
module dar_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dar_pkg::sts_type sts,
   output dar_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_GTEST  = 3'd1;
   localparam logic [2:0] S_GWAIT  = 3'd2;
   localparam logic [2:0] S_WWAIT  = 3'd3;
   localparam logic [2:0] S_HWAIT  = 3'd4;
   localparam logic [2:0] S_CHECK  = 3'd5;
   localparam logic [2:0] S_SEARCH = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] out_sel_ff, out_sel_in;

   always_comb begin
      cmd         = '0;
      cmd.out_sel = out_sel_ff;
      state_in    = state_ff;
      out_sel_in  = out_sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.in_zero) begin
                  out_sel_in = dar_pkg::OUT_SEL_INVALID;
                  state_in   = S_OUT;
               end else begin
                  state_in = S_GTEST;
               end
            end
         end
         S_GTEST: begin
            cmd.div_start = 1'b1;
            if (sts.b_zero) begin
               cmd.div_sel = dar_pkg::DIV_SEL_W;
               state_in    = S_WWAIT;
            end else begin
               cmd.div_sel = dar_pkg::DIV_SEL_GCD;
               state_in    = S_GWAIT;
            end
         end
         S_GWAIT: begin
            if (sts.div_done) begin
               cmd.gcd_step = 1'b1;
               state_in     = S_GTEST;
            end
         end
         S_WWAIT: begin
            if (sts.div_done) begin
               cmd.wr_w      = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = dar_pkg::DIV_SEL_H;
               state_in      = S_HWAIT;
            end
         end
         S_HWAIT: begin
            if (sts.div_done) begin
               cmd.wr_h = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.rw_gt_limit) begin
               cmd.srch_init = 1'b1;
               state_in      = S_SEARCH;
            end else begin
               out_sel_in = dar_pkg::OUT_SEL_RATIO;
               state_in   = S_OUT;
            end
         end
         S_SEARCH: begin
            cmd.srch_step = 1'b1;
            if (sts.hit) begin
               // matched pair goes back through Euclid to be reduced
               cmd.load_pair = 1'b1;
               state_in      = S_GTEST;
            end else if (sts.miss_end) begin
               out_sel_in = dar_pkg::OUT_SEL_ZERO;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      out_sel_ff <= out_sel_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

@@ src/display_aspect_ratio_reducer_top.sv @@
// Top level of the display aspect ratio reducer.
//
//   beat   | dir | handshake            | payload
//   req    | in  | req_valid/req_stall  | frame_width, frame_height
//   rsp    | out | rsp_valid/rsp_stall  | ratio_num, ratio_den, invalid
//
// One beat in, one beat out. Each Euclid remainder step is one pass through
// the shared 16-step restoring divider; reducing width and height takes two
// more divides. The search tests one candidate per cycle, over at most
// SEARCH_LIMIT^2 candidates, then the matched pair is reduced the same way.
// Reset is synchronous and clears the controller, divider and output valid.
// req_stall is high while an item is in work; a held result only blocks the
// finish of the next item.
`include "assert_macros.svh"

module display_aspect_ratio_reducer_top #(
   parameter int SEARCH_LIMIT = dar_pkg::SEARCH_LIMIT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [dar_pkg::WORD_W-1:0] req_frame_width,
   input  logic [dar_pkg::WORD_W-1:0] req_frame_height,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [dar_pkg::WORD_W-1:0] rsp_ratio_num,
   output logic [dar_pkg::WORD_W-1:0] rsp_ratio_den,
   output logic                       rsp_invalid
);

   localparam logic [dar_pkg::WORD_W-1:0] LIMIT_W = dar_pkg::WORD_W'(SEARCH_LIMIT);

   dar_pkg::cmd_type cmd;
   dar_pkg::sts_type sts;
   logic             rsp_ratio_zero;

   dar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dar_dpath #(
      .SEARCH_LIMIT (SEARCH_LIMIT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_frame_width  (req_frame_width),
      .req_frame_height (req_frame_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ratio_num    (rsp_ratio_num),
      .rsp_ratio_den    (rsp_ratio_den),
      .rsp_invalid      (rsp_invalid)
   );

   assign rsp_ratio_zero = (rsp_ratio_num == '0) && (rsp_ratio_den == '0);

   `DAR_ASSERT_IMP(a_inv_zero, clock, reset, rsp_valid && rsp_invalid, rsp_ratio_zero)
   `DAR_ASSERT_IMP(a_num_limit, clock, reset, rsp_valid, rsp_ratio_num <= LIMIT_W)
   `DAR_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `DAR_ASSERT_IMP(a_pair_from_search, clock, reset, cmd.load_pair, cmd.srch_step && !cmd.load_out)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the display aspect ratio reducer top level.
`timescale 1ns / 1ps

module testbench;

   localparam int          LIMIT       = dar_pkg::SEARCH_LIMIT_DEF;
   localparam int          RANDOM_N    = 650;
   localparam int          SETTLE_CYC  = 1200;
   localparam int          HOLD_CYC    = 4000;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   typedef struct {
      logic [dar_pkg::WORD_W-1:0] fw;
      logic [dar_pkg::WORD_W-1:0] fh;
      bit                         pause;
   } frame_type;

   typedef struct {
      logic [dar_pkg::WORD_W-1:0] ratio_num;
      logic [dar_pkg::WORD_W-1:0] ratio_den;
      logic                       invalid;
   } ratio_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [dar_pkg::WORD_W-1:0] req_frame_width = '0;
   logic [dar_pkg::WORD_W-1:0] req_frame_height = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [dar_pkg::WORD_W-1:0] rsp_ratio_num;
   logic [dar_pkg::WORD_W-1:0] rsp_ratio_den;
   logic                       rsp_invalid;

   frame_type   pending_frames[$];
   ratio_type   expected_ratios[$];
   int          frames_total = 0;
   int          frames_accepted = 0;
   int          ratios_seen = 0;
   int          failures = 0;
   int unsigned cycle_count = 0;

   int gap_left = 0;
   int burst_left = 1;
   int hold_left = 0;
   int next_hold_at = 150;
   int stall_mode = 0;
   int mode_left = 0;

   display_aspect_ratio_reducer_top #(.SEARCH_LIMIT(LIMIT)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_width  (req_frame_width),
      .req_frame_height (req_frame_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ratio_num    (rsp_ratio_num),
      .rsp_ratio_den    (rsp_ratio_den),
      .rsp_invalid      (rsp_invalid)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned common_divisor(int unsigned a, int unsigned b);
      int unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic ratio_type predict_ratio(logic [dar_pkg::WORD_W-1:0] fw,
                                               logic [dar_pkg::WORD_W-1:0] fh);
      ratio_type   r;
      int unsigned g, rw, rh, cw, ch, lhs, rhs, dif;
      bit          found;
      r.ratio_num = '0;
      r.ratio_den = '0;
      r.invalid   = 1'b0;
      if (fw == 0 || fh == 0) begin
         r.invalid = 1'b1;
         return r;
      end
      g  = common_divisor(fw, fh);
      rw = fw / g;
      rh = fh / g;
      if (rw <= LIMIT) begin
         r.ratio_num = rw[dar_pkg::WORD_W-1:0];
         r.ratio_den = rh[dar_pkg::WORD_W-1:0];
         return r;
      end
      found = 1'b0;
      for (cw = LIMIT; cw > 0 && !found; cw--) begin
         for (ch = LIMIT; ch > 0 && !found; ch--) begin
            lhs = rw * ch;
            rhs = cw * rh;
            dif = (lhs > rhs) ? lhs - rhs : rhs - lhs;
            if (100 * dif < lhs) begin
               g           = common_divisor(cw, ch);
               r.ratio_num = dar_pkg::WORD_W'(cw / g);
               r.ratio_den = dar_pkg::WORD_W'(ch / g);
               found       = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic add_frame(int unsigned fw, int unsigned fh, bit pause);
      frame_type f;
      f.fw    = fw[dar_pkg::WORD_W-1:0];
      f.fh    = fh[dar_pkg::WORD_W-1:0];
      f.pause = pause;
      pending_frames.push_back(f);
      frames_total++;
   endtask

   // Mix of common ratios scaled up, near misses, raw noise, zeros and tiny sizes.
   task automatic add_random_frame(bit pause);
      int unsigned pick, a, b, m, k, fw, fh;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         fw = $urandom_range(0, 65535);
         fh = $urandom_range(0, 65535);
         if ($urandom_range(0, 1) == 0) fw = 0;
         else fh = 0;
      end else if (pick < 38) begin
         fw = $urandom_range(1, 65535);
         fh = $urandom_range(1, 65535);
      end else if (pick < 78) begin
         a  = $urandom_range(1, 21);
         b  = $urandom_range(1, 40);
         m  = (a > b) ? a : b;
         k  = $urandom_range(1, 65535 / m);
         fw = a * k;
         fh = b * k;
      end else if (pick < 93) begin
         a  = $urandom_range(1, 21);
         b  = $urandom_range(1, 21);
         m  = (a > b) ? a : b;
         k  = $urandom_range(20, 65535 / (m + 1));
         fw = a * k + $urandom_range(0, k / 40);
         fh = b * k + $urandom_range(0, k / 40);
      end else begin
         fw = $urandom_range(1, 64);
         fh = $urandom_range(1, 64);
      end
      add_frame(fw, fh, pause);
   endtask

   // Sender: bursts with random gaps; a paused frame waits for an empty pipe.
   always @(posedge clock) begin
      frame_type nxt;
      bit        offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_ratios.push_back(predict_ratio(req_frame_width, req_frame_height));
            frames_accepted++;
         end
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_frames.size() > 0 &&
                         (!pending_frames[0].pause || expected_ratios.size() == 0)) begin
               nxt   = pending_frames.pop_front();
               offer = 1'b1;
               req_frame_width  <= nxt.fw;
               req_frame_height <= nxt.fh;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
               end
            end
            req_valid <= offer;
         end
      end
   end

   // Receiver: random stall pattern, plus long hold-offs to back up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (ratios_seen >= next_hold_at) begin
         hold_left    = HOLD_CYC;
         next_hold_at = next_hold_at + 300;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ~rsp_stall;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      ratio_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         ratios_seen++;
         if (expected_ratios.size() == 0) begin
            if (failures < 10)
               $display("unexpected beat: num=%0d den=%0d invalid=%0b",
                        rsp_ratio_num, rsp_ratio_den, rsp_invalid);
            failures++;
         end else begin
            want = expected_ratios.pop_front();
            if (rsp_ratio_num !== want.ratio_num || rsp_ratio_den !== want.ratio_den ||
                rsp_invalid !== want.invalid) begin
               if (failures < 10)
                  $display("mismatch: expected %0d:%0d invalid=%0b, got %0d:%0d invalid=%0b",
                           want.ratio_num, want.ratio_den, want.invalid,
                           rsp_ratio_num, rsp_ratio_den, rsp_invalid);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      int n;
      add_frame(0, 0, 1'b0);
      add_frame(0, 1080, 1'b0);
      add_frame(1920, 0, 1'b0);
      add_frame(1, 1, 1'b0);
      add_frame(65535, 65535, 1'b0);
      add_frame(1, 65535, 1'b0);
      add_frame(65535, 1, 1'b0);
      add_frame(1920, 1080, 1'b0);
      add_frame(1280, 720, 1'b1);
      add_frame(3840, 2160, 1'b0);
      add_frame(2560, 1080, 1'b0);
      add_frame(1366, 768, 1'b0);
      add_frame(1280, 1024, 1'b0);
      add_frame(21, 65535, 1'b0);
      add_frame(22, 65535, 1'b0);
      add_frame(65535, 2, 1'b0);
      add_frame(1024, 1000, 1'b0);
      add_frame(43690, 21845, 1'b0);
      add_frame(32768, 16384, 1'b0);
      add_frame(65534, 43689, 1'b0);
      add_frame(2, 4, 1'b0);
      add_frame(42, 2, 1'b0);
      add_frame(1600, 1200, 1'b0);
      for (n = 0; n < RANDOM_N; n++)
         add_random_frame(n == 50 || n == 350);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (frames_accepted < frames_total || expected_ratios.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);

      if (expected_ratios.size() != 0) begin
         if (failures < 10)
            $display("%0d results never arrived", expected_ratios.size());
         failures++;
      end
      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/dar_pkg.sv
src/dar_div.sv
src/dar_dpath.sv
src/dar_ctrl.sv
src/display_aspect_ratio_reducer_top.sv
tb/testbench.sv
